/* src/terminal_escape_key_decoder_assert.svh */
// Assertion macros for the terminal escape key decoder.
// Expects the including module to provide clock and reset; no other dependencies.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TEKD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tekd assertion failed");
`define TEKD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tekd assertion failed");
`else
`define TEKD_ASSERT(lbl, prop)
`define TEKD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/tekd_pkg.sv */
// Package for the terminal escape key decoder: character codes, key codes,
// request codes and the result word type. No dependencies.
package tekd_pkg;

   localparam logic       REQ_BYTE = 1'b0;
   localparam logic       REQ_TICK = 1'b1;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_LBRK  = 8'h5B; // '['
   localparam logic [7:0] CH_O     = 8'h4F; // 'O'
   localparam logic [7:0] CH_TILDE = 8'h7E; // '~'
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_2     = 8'h32;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_5     = 8'h35;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_8     = 8'h38;
   localparam logic [7:0] CH_9     = 8'h39;

   localparam logic [3:0] KEY_UP    = 4'd0;
   localparam logic [3:0] KEY_DOWN  = 4'd1;
   localparam logic [3:0] KEY_LEFT  = 4'd2;
   localparam logic [3:0] KEY_RIGHT = 4'd3;
   localparam logic [3:0] KEY_HOME  = 4'd4;
   localparam logic [3:0] KEY_END   = 4'd5;
   localparam logic [3:0] KEY_F1    = 4'd6;
   localparam logic [3:0] KEY_F5    = 4'd10;
   localparam logic [3:0] KEY_F6    = 4'd11;
   localparam logic [3:0] KEY_F7    = 4'd12;
   localparam logic [3:0] KEY_F8    = 4'd13;
   localparam logic [3:0] KEY_F9    = 4'd14;
   localparam logic [3:0] KEY_F10   = 4'd15;
   localparam logic [3:0] KEY_NONE  = 4'd0;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] TICK_MAX      = 16'hFFFF;

   // Bytes after ESC that matching ever looks at from storage
   localparam int SEQ_STORE = 3;

   typedef struct packed {
      logic       is_special;
      logic [7:0] char_code;
      logic [3:0] special_key;
   } rsp_word_type;

endpackage

/* src/terminal_escape_key_decoder.sv */
// Terminal escape key decoder top level: byte mapping, escape sequence
// matching, lone ESC timeout and a two-word output stage. Uses tekd_pkg.
//
// Decodes a stream of received terminal bytes and time ticks into keys. Each
// request word (a byte or one tick) is decoded against the stored escape state
// in one pass of compare logic; a resulting key word goes into the output
// register, or into its skid stage while that register is held. One request
// is accepted every cycle as long as the output register and its skid stage
// are not both full, so a stalled consumer holds off the producer only after
// two undelivered key words. CR is delivered as LF and DEL as backspace. ESC
// opens a sequence of up to BUF_LEN bytes; arrow, Home, End, F1-F10 and the
// Delete sequence produce a key, a full buffer with no match is dropped, and
// an ESC followed only by ticks reaching csr escape_timeout yields a lone ESC.
`include "terminal_escape_key_decoder_assert.svh"

module terminal_escape_key_decoder #(
   parameter int BUF_LEN = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_special,
   output logic [7:0]  rsp_char_code,
   output logic [3:0]  rsp_special_key
);

   localparam int CNT_W = $clog2(BUF_LEN);
   localparam logic [CNT_W:0] FULL_CNT = (CNT_W + 1)'(BUF_LEN);

   // Decoder state
   logic [15:0]      timeout_ff, timeout_in;
   logic             in_esc_ff, in_esc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic [7:0]       seq_ff [tekd_pkg::SEQ_STORE];

   // Output stage
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   tekd_pkg::rsp_word_type out_ff, out_in;
   tekd_pkg::rsp_word_type skid_ff, skid_in;

   logic                   accept, take, push;
   logic [7:0]             ch;
   logic [CNT_W:0]         count_next;
   logic [15:0]            elapsed_inc;
   logic                   match_special, match_plain, seq_close, seq_write;
   logic [3:0]             match_key;
   tekd_pkg::rsp_word_type new_word;

   assign accept = req_valid && req_ready;
   assign take   = rsp_valid && rsp_ready;
   assign req_ready = !skid_valid_ff;

   // CR/DEL mapping happens before anything else looks at the byte
   always_comb begin
      if (req_rx_byte == tekd_pkg::CH_CR) begin
         ch = tekd_pkg::CH_LF;
      end else if (req_rx_byte == tekd_pkg::CH_DEL) begin
         ch = tekd_pkg::CH_BS;
      end else begin
         ch = req_rx_byte;
      end
   end

   assign count_next  = {1'b0, count_ff} + (CNT_W + 1)'(1);
   assign elapsed_inc = (elapsed_ff == tekd_pkg::TICK_MAX) ? elapsed_ff : elapsed_ff + 16'd1;

   // Sequence match; the byte just received is the last byte of the candidate
   always_comb begin
      match_special = 1'b0;
      match_plain   = 1'b0;
      match_key     = tekd_pkg::KEY_NONE;
      if (count_ff == CNT_W'(1)) begin
         if (seq_ff[0] == tekd_pkg::CH_LBRK) begin
            match_special = 1'b1;
            case (ch)
               tekd_pkg::CH_A: match_key = tekd_pkg::KEY_UP;
               tekd_pkg::CH_B: match_key = tekd_pkg::KEY_DOWN;
               tekd_pkg::CH_D: match_key = tekd_pkg::KEY_LEFT;
               tekd_pkg::CH_C: match_key = tekd_pkg::KEY_RIGHT;
               tekd_pkg::CH_H: match_key = tekd_pkg::KEY_HOME;
               tekd_pkg::CH_F: match_key = tekd_pkg::KEY_END;
               default:        match_special = 1'b0;
            endcase
         end else if (seq_ff[0] == tekd_pkg::CH_O
                      && (ch inside {[tekd_pkg::CH_P:tekd_pkg::CH_S]})) begin
            // P..S sit on consecutive codes starting at a multiple of four
            match_special = 1'b1;
            match_key     = tekd_pkg::KEY_F1 + {2'b00, ch[1:0]};
         end
      end else if (count_ff == CNT_W'(2)) begin
         match_plain = (seq_ff[0] == tekd_pkg::CH_LBRK) && (seq_ff[1] == tekd_pkg::CH_3)
                       && (ch == tekd_pkg::CH_TILDE);
      end else if (count_ff == CNT_W'(3)) begin
         if (seq_ff[0] == tekd_pkg::CH_LBRK && ch == tekd_pkg::CH_TILDE) begin
            if (seq_ff[1] == tekd_pkg::CH_1) begin
               match_special = 1'b1;
               case (seq_ff[2])
                  tekd_pkg::CH_5: match_key = tekd_pkg::KEY_F5;
                  tekd_pkg::CH_7: match_key = tekd_pkg::KEY_F6;
                  tekd_pkg::CH_8: match_key = tekd_pkg::KEY_F7;
                  tekd_pkg::CH_9: match_key = tekd_pkg::KEY_F8;
                  default:        match_special = 1'b0;
               endcase
            end else if (seq_ff[1] == tekd_pkg::CH_2) begin
               match_special = 1'b1;
               case (seq_ff[2])
                  tekd_pkg::CH_0: match_key = tekd_pkg::KEY_F9;
                  tekd_pkg::CH_1: match_key = tekd_pkg::KEY_F10;
                  default:        match_special = 1'b0;
               endcase
            end
         end
      end
   end

   assign seq_close = match_special || match_plain || (count_next >= FULL_CNT);

   // State update and result generation for one accepted word
   always_comb begin
      timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;
      in_esc_in  = in_esc_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      seq_write  = 1'b0;
      push       = 1'b0;
      new_word   = '{is_special: 1'b0, char_code: tekd_pkg::CH_NUL,
                     special_key: tekd_pkg::KEY_NONE};
      if (accept) begin
         if (req_type == tekd_pkg::REQ_TICK) begin
            elapsed_in = elapsed_inc;
            if (in_esc_ff && count_ff == '0 && elapsed_inc >= timeout_ff) begin
               in_esc_in          = 1'b0;
               push               = 1'b1;
               new_word.char_code = tekd_pkg::CH_ESC;
            end
         end else if (!in_esc_ff) begin
            if (ch == tekd_pkg::CH_ESC) begin
               in_esc_in  = 1'b1;
               count_in   = '0;
               elapsed_in = '0;
            end else begin
               push               = 1'b1;
               new_word.char_code = ch;
            end
         end else begin
            seq_write = (count_ff < CNT_W'(tekd_pkg::SEQ_STORE));
            if (seq_close) begin
               in_esc_in = 1'b0;
               count_in  = '0;
            end else begin
               count_in  = count_next[CNT_W-1:0];
            end
            if (match_special) begin
               push                 = 1'b1;
               new_word.is_special  = 1'b1;
               new_word.special_key = match_key;
            end else if (match_plain) begin
               push               = 1'b1;
               new_word.char_code = tekd_pkg::CH_DEL;
            end
         end
      end
   end

   // Output register with a skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !take) begin
         if (push) begin
            skid_in       = new_word;
            skid_valid_in = 1'b1;
         end
      end else begin
         out_valid_in = push;
         out_in       = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= tekd_pkg::TIMEOUT_RESET;
         in_esc_ff     <= 1'b0;
         count_ff      <= '0;
         elapsed_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         in_esc_ff     <= in_esc_in;
         count_ff      <= count_in;
         elapsed_ff    <= elapsed_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (seq_write) begin
         seq_ff[count_ff[1:0]] <= ch;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_is_special  = out_ff.is_special;
   assign rsp_char_code   = out_ff.char_code;
   assign rsp_special_key = out_ff.special_key;

   // Skid word never exists without a word in the output register
   `TEKD_ASSERT(a_skid_behind_out, !skid_valid_ff || out_valid_ff)
   // Collected bytes only exist inside an open sequence
   `TEKD_ASSERT(a_count_in_seq, count_ff == '0 || in_esc_ff)
   // A sequence never stays open with a full buffer
   `TEKD_ASSERT(a_count_bound, (CNT_W + 1)'(count_ff) < FULL_CNT)
   // A byte accepted outside a sequence always produces a word or opens one
   `TEKD_ASSERT_NEXT(a_plain_byte,
      accept && req_type == tekd_pkg::REQ_BYTE && !in_esc_ff,
      rsp_valid || in_esc_ff)

endmodule
